// ----- src/mqts_pkg.sv -----
package mqts_pkg;

    // Port field width and parameter defaults
    localparam int FIELD_W     = 32;
    localparam int DEPTH_DEF   = 64;
    localparam int DATA_W_DEF  = 32;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_XRD,
        ST_XWR,
        ST_POP,
        ST_POPRD,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed
    {
        logic start;    // item accepted: clear popped, latch error
        err_t err;
        logic push;     // write input stack
        logic xfer_rd;  // read top of input stack
        logic xfer_wr;  // move read value onto output stack
        logic pop;      // remove output top, read entry below
        logic pop_load; // refresh cached output top
        logic emit;     // load result register
    } mq_cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic in_empty;
        logic in_full;
        logic in_one;
        logic out_empty;
        logic slot_free;
    } mq_stat_t;

endpackage

// ----- src/mqts_ctrl.sv -----
module mqts_ctrl
    import mqts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     op,
    output logic     in_ready,
    input  mq_stat_t stat,
    output mq_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    op_t    op_in;

    assign op_in = op_t'(op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op_in == OP_PUSH)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (stat.in_empty && stat.out_empty)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (stat.out_empty)
                    begin
                        state_next = ST_XRD;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_XRD:   state_next = ST_XWR;
            ST_XWR:   state_next = stat.in_one ? ST_POP : ST_XRD;
            ST_POP:   state_next = ST_POPRD;
            ST_POPRD: state_next = ST_EMIT;
            ST_EMIT:  state_next = stat.slot_free ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.err  = ERR_OK;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
                if (in_valid)
                begin
                    if (op_in == OP_PUSH)
                    begin
                        if (stat.in_full)
                        begin
                            cmd.err = ERR_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (stat.in_empty && stat.out_empty)
                    begin
                        cmd.err = ERR_EMPTY;
                    end
                end
            end
            ST_XRD:   cmd.xfer_rd  = 1'b1;
            ST_XWR:   cmd.xfer_wr  = 1'b1;
            ST_POP:   cmd.pop      = 1'b1;
            ST_POPRD: cmd.pop_load = 1'b1;
            ST_EMIT:  cmd.emit     = stat.slot_free;
            default:  cmd.start    = 1'b0;
        endcase
    end

endmodule

// ----- src/mqts_dp.sv -----
module mqts_dp
    import mqts_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [FIELD_W-1:0] data_in,
    input  mq_cmd_t                   cmd,
    output mq_stat_t                  stat,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [FIELD_W-1:0] popped_value,
    output logic signed [FIELD_W-1:0] queue_max,
    output logic                      max_valid,
    output logic                      is_empty,
    output logic [1:0]                error_code
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic signed [DATA_WIDTH-1:0]   in_mem [DEPTH];
    logic        [2*DATA_WIDTH-1:0] out_mem [DEPTH];

    logic [CW-1:0]                in_count_reg;
    logic [CW-1:0]                out_count_reg;
    logic signed [DATA_WIDTH-1:0] in_max_reg;
    logic signed [DATA_WIDTH-1:0] top_val_reg;
    logic signed [DATA_WIDTH-1:0] top_smax_reg;
    logic signed [DATA_WIDTH-1:0] popped_reg;
    err_t                         err_reg;
    logic signed [DATA_WIDTH-1:0] rd_in_reg;
    logic        [2*DATA_WIDTH-1:0] rd_out_reg;
    logic                         out_valid_reg;
    logic signed [FIELD_W-1:0]    popped_value_reg;
    logic signed [FIELD_W-1:0]    queue_max_reg;
    logic                         max_valid_reg;
    logic                         is_empty_reg;
    err_t                         error_code_reg;

    logic signed [DATA_WIDTH-1:0] v_in;
    logic signed [DATA_WIDTH-1:0] xfer_smax;
    logic signed [DATA_WIDTH-1:0] qmax;
    logic [AW-1:0]                in_wr_idx;
    logic [AW-1:0]                in_rd_idx;
    logic [AW-1:0]                out_wr_idx;
    logic [AW-1:0]                out_rd_idx;
    logic                         in_zero;
    logic                         out_zero;
    logic                         q_empty;

    assign v_in       = data_in[DATA_WIDTH-1:0];
    assign in_wr_idx  = in_count_reg[AW-1:0];
    assign in_rd_idx  = in_count_reg[AW-1:0] - AW'(1);
    assign out_wr_idx = out_count_reg[AW-1:0];
    // entry just below the current top
    assign out_rd_idx = out_count_reg[AW-1:0] - AW'(2);
    assign in_zero    = (in_count_reg == '0);
    assign out_zero   = (out_count_reg == '0);
    assign q_empty    = in_zero && out_zero;

    assign xfer_smax = (!out_zero && (top_smax_reg > rd_in_reg)) ? top_smax_reg : rd_in_reg;

    always_comb
    begin
        if (q_empty)
        begin
            qmax = '0;
        end
        else if (in_zero)
        begin
            qmax = top_smax_reg;
        end
        else if (out_zero)
        begin
            qmax = in_max_reg;
        end
        else
        begin
            qmax = (in_max_reg > top_smax_reg) ? in_max_reg : top_smax_reg;
        end
    end

    assign stat.in_empty  = in_zero;
    assign stat.in_full   = (in_count_reg == FULL_CNT);
    assign stat.in_one    = (in_count_reg == CW'(1));
    assign stat.out_empty = out_zero;
    assign stat.slot_free = !out_valid_reg || out_ready;

    // Stack memories
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            in_mem[in_wr_idx] <= v_in;
        end
        if (cmd.xfer_rd)
        begin
            rd_in_reg <= in_mem[in_rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.xfer_wr)
        begin
            out_mem[out_wr_idx] <= {rd_in_reg, xfer_smax};
        end
        if (cmd.pop)
        begin
            rd_out_reg <= out_mem[out_rd_idx];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            popped_reg <= '0;
            err_reg    <= cmd.err;
        end
        if (cmd.xfer_wr)
        begin
            top_val_reg  <= rd_in_reg;
            top_smax_reg <= xfer_smax;
        end
        if (cmd.pop)
        begin
            popped_reg <= top_val_reg;
        end
        if (cmd.pop_load && !out_zero)
        begin
            top_val_reg  <= rd_out_reg[2*DATA_WIDTH-1:DATA_WIDTH];
            top_smax_reg <= rd_out_reg[DATA_WIDTH-1:0];
        end
        if (cmd.emit)
        begin
            popped_value_reg <= FIELD_W'(popped_reg);
            queue_max_reg    <= FIELD_W'(qmax);
            max_valid_reg    <= !q_empty;
            is_empty_reg     <= q_empty;
            error_code_reg   <= err_reg;
        end
    end

    // Counts, running max, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= '0;
            out_count_reg <= '0;
            in_max_reg    <= MIN_VAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                in_count_reg <= in_count_reg + CW'(1);
                if (v_in > in_max_reg)
                begin
                    in_max_reg <= v_in;
                end
            end
            if (cmd.xfer_wr)
            begin
                in_count_reg  <= in_count_reg - CW'(1);
                out_count_reg <= out_count_reg + CW'(1);
                in_max_reg    <= MIN_VAL;
            end
            if (cmd.pop)
            begin
                out_count_reg <= out_count_reg - CW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_value_reg;
    assign queue_max    = queue_max_reg;
    assign max_valid    = max_valid_reg;
    assign is_empty     = is_empty_reg;
    assign error_code   = error_code_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (in_count_reg <= FULL_CNT) && (out_count_reg <= FULL_CNT))
        else $error("stack count beyond depth");

    a_xfer_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.xfer_wr |-> !in_zero)
        else $error("transfer from empty input stack");

    a_pop_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !out_zero)
        else $error("pop from empty output stack");

    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (err_reg == ERR_EMPTY)) |-> q_empty)
        else $error("empty-pop error on non-empty queue");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("result not presented after emit");

endmodule

// ----- src/max_queue_two_stacks.sv -----
// FIFO of signed values that also reports the largest value held, built as two stacks.
// Push writes the input stack and updates its running max; pop takes the oldest value
// from the output stack of (value, suffix max) pairs, first moving the whole input stack
// across when the output stack is empty. Each accepted beat gives exactly one result beat
// with the popped value, queue max, max_valid, is_empty and error_code (1 = pop on empty,
// 2 = push on full; either leaves the queue unchanged). Sequence: a push, or either error,
// goes from the accept to the result state, which loads the output register and raises
// out_valid once the output slot is free; a pop with the output stack non-empty passes
// through the pop and pop-read states before the result state; a pop that triggers a
// transfer first runs one read state and one write state for each value moved. A value
// is pushed, moved and popped once. One beat is in flight at a time; a finished result
// sits in the output register so the next beat is taken while it waits, and a second
// finished result holds in_ready low until the first is taken.
// DATA_WIDTH low bits of data_in are used, sign-extended on the outputs. No clearing pass.
module max_queue_two_stacks
    import mqts_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input beat
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic signed [FIELD_W-1:0] data_in,
    // result beat
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [FIELD_W-1:0] popped_value,
    output logic signed [FIELD_W-1:0] queue_max,
    output logic                      max_valid,
    output logic                      is_empty,
    output logic [1:0]                error_code
);

    mq_cmd_t  cmd;
    mq_stat_t stat;

    // Sequencer: decode, transfer loop, pop, result hand-off
    mqts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Stacks, counts, cached output top, result register
    mqts_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_in      (data_in),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .popped_value (popped_value),
        .queue_max    (queue_max),
        .max_valid    (max_valid),
        .is_empty     (is_empty),
        .error_code   (error_code)
    );

endmodule
